[hdl/i2rs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2rs_pkg;

    localparam int VAL_W       = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int MAX_DIGITS  = 32;
    localparam int DIG_IDX_W   = $clog2(MAX_DIGITS);
    localparam int DIG_CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int BIT_CNT_W   = $clog2(VAL_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 7'h57;  // 'a' - 10
    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 7'h2d;  // '-'
    localparam logic [CHAR_W-1:0] CHAR_NINE      = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z     = 7'h7a;

    // one classified item waiting for the digit engine
    typedef struct packed {
        logic               neg;
        logic [VAL_W-1:0]   mag;
        logic [RADIX_W-1:0] radix;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_STORE,
        BK_SIGN,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic load_job;
        logic div_step;
        logic store_digit;
        logic load_sign;
        logic load_digit;
    } t_back_ctl;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (d < DIGIT_TEN) begin
            digit_to_char = CHAR_ZERO + d_ext;
        end else begin
            digit_to_char = CHAR_ALPHA_OFS + d_ext;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/i2rs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2rs_front import i2rs_pkg::*; (
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic [VAL_W-1:0]   i_value,
    input  wire logic [RADIX_W-1:0] i_radix,
    output      logic               o_push,
    input  wire logic               i_push_ready,
    output      t_job               o_job
);

    logic [RADIX_W-1:0] radix_clamped;

    // clamp radix and split into sign and magnitude
    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    assign o_job.neg   = i_value[VAL_W-1];
    // the most negative value wraps to its true unsigned magnitude
    assign o_job.mag   = i_value[VAL_W-1] ? (~i_value + {{(VAL_W-1){1'b0}}, 1'b1}) : i_value;
    assign o_job.radix = radix_clamped;

    assign o_ready = i_push_ready & i_rst_n;
    assign o_push  = i_valid & o_ready;

endmodule

`default_nettype wire

[hdl/i2rs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2rs_queue import i2rs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output      logic o_push_ready,
    input  wire t_job i_job,
    output      logic o_pop_valid,
    input  wire logic i_pop,
    output      t_job o_job
);

    t_job               r_entry [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_push;
    logic               do_pop;

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_job        = r_entry[r_rd_ptr];
    assign do_push      = i_push & o_push_ready;
    assign do_pop       = i_pop & o_pop_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[hdl/i2rs_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2rs_back import i2rs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    output      logic              o_pop,
    input  wire t_job              i_job,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [CHAR_W-1:0] o_char_out,
    output      logic              o_last
);

    t_back_state          r_state;
    t_back_state          n_state;
    t_back_ctl            ctl;
    logic                 r_neg;
    logic [VAL_W-1:0]     r_mag;
    logic [RADIX_W-1:0]   r_rem;
    logic [RADIX_W-1:0]   r_radix;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [DIG_CNT_W-1:0] r_ndig;
    logic [DIG_IDX_W-1:0] r_idx;
    logic [CHAR_W-1:0]    r_digit [MAX_DIGITS];
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;

    logic                 slot_free;
    logic [RADIX_W:0]     rem_sh;
    logic                 q_bit;
    logic [RADIX_W:0]     rem_diff;
    logic                 more_digits;
    logic                 last_bit;

    assign slot_free = !r_out_valid || i_ready;

    // one restoring shift-subtract step per cycle
    assign rem_sh   = {r_rem, r_mag[VAL_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_radix});
    assign rem_diff = q_bit ? (rem_sh - {1'b0, r_radix}) : rem_sh;
    assign last_bit = (r_bit_cnt == BIT_CNT_W'(VAL_W - 1));

    assign more_digits = (r_mag != '0) && (r_ndig < DIG_CNT_W'(MAX_DIGITS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_bit) begin
                    n_state = BK_STORE;
                end
            end
            BK_STORE: begin
                if (more_digits) begin
                    n_state = BK_DIV;
                end else if (r_neg) begin
                    n_state = BK_SIGN;
                end else begin
                    n_state = BK_EMIT;
                end
            end
            BK_SIGN: begin
                if (slot_free) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (slot_free && r_idx == '0) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        case (r_state)
            BK_IDLE: begin
                ctl.pop      = i_job_valid;
                ctl.load_job = i_job_valid;
            end
            BK_DIV: begin
                ctl.div_step = 1'b1;
            end
            BK_STORE: begin
                ctl.store_digit = 1'b1;
            end
            BK_SIGN: begin
                ctl.load_sign = slot_free;
            end
            BK_EMIT: begin
                ctl.load_digit = slot_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    assign o_pop = ctl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load_sign || ctl.load_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load_job) begin
            r_neg     <= i_job.neg;
            r_mag     <= i_job.mag;
            r_radix   <= i_job.radix;
            r_rem     <= '0;
            r_bit_cnt <= '0;
            r_ndig    <= '0;
        end
        if (ctl.div_step) begin
            r_mag     <= {r_mag[VAL_W-2:0], q_bit};
            r_rem     <= rem_diff[RADIX_W-1:0];
            r_bit_cnt <= r_bit_cnt + 1'b1;
        end
        if (ctl.store_digit) begin
            r_digit[r_ndig[DIG_IDX_W-1:0]] <= digit_to_char(r_rem);
            r_ndig    <= r_ndig + 1'b1;
            r_idx     <= r_ndig[DIG_IDX_W-1:0];
            r_rem     <= '0;
            r_bit_cnt <= '0;
        end
        if (ctl.load_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end
        if (ctl.load_digit) begin
            r_out_char <= r_digit[r_idx];
            r_out_last <= (r_idx == '0);
            r_idx      <= r_idx - 1'b1;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char_out = r_out_char;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

[hdl/int_to_radix_string.sv]
`timescale 1ns / 1ps
`default_nettype none

// int_to_radix_string: turns a signed 32-bit item into its ASCII text in a
// radix from 2 to 36, one character per output item, most significant first,
// with a leading '-' for negative values and last set on the final character.
// a radix below 2 is taken as 2 and one above 36 as 36; the most negative
// value prints as its full magnitude. the front clamps the radix and takes
// the magnitude in the cycle of acceptance and drops the item into a
// two-entry queue, so up to two items can be taken while the back end is busy.
// the back end works on one item at a time: each digit takes a shift-subtract
// division of the whole magnitude (one quotient bit per cycle) plus a store
// step, then the characters leave through an output register at one per
// cycle while the sink is ready. reset clears the queue and the output valid
// flag; no clearing pass is needed

module int_to_radix_string import i2rs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire logic [VAL_W-1:0]   i_value,
    input  wire logic [RADIX_W-1:0] i_radix,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      logic [CHAR_W-1:0]  o_char_out,
    output      logic               o_last
);

    // front to queue
    logic front_push;
    logic q_push_ready;
    t_job front_job;

    // queue to back end
    logic q_pop_valid;
    logic back_pop;
    t_job q_job;

    // classify: radix clamp, sign and magnitude
    i2rs_front u_front (
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_push       (front_push),
        .i_push_ready (q_push_ready),
        .o_job        (front_job)
    );

    // short decoupling queue between accept side and digit engine
    i2rs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (q_push_ready),
        .i_job        (front_job),
        .o_pop_valid  (q_pop_valid),
        .i_pop        (back_pop),
        .o_job        (q_job)
    );

    // digit engine: repeated division, digit buffer, reversed emission
    i2rs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_pop_valid),
        .o_pop       (back_pop),
        .i_job       (q_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_out  (o_char_out),
        .o_last      (o_last)
    );

    // the engine only ever sees a clamped radix
    a_radix_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop_valid && back_pop) |-> (q_job.radix >= RADIX_MIN && q_job.radix <= RADIX_MAX))
        else $error("job radix out of range");

    // every character is a sign, a decimal digit or a lower-case letter
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_out == CHAR_MINUS
                     || (o_char_out >= CHAR_ZERO && o_char_out <= CHAR_NINE)
                     || (o_char_out >= CHAR_LOW_A && o_char_out <= CHAR_LOW_Z)))
        else $error("illegal output character");

    // a sign never ends the text
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_out == CHAR_MINUS) |-> !o_last)
        else $error("sign flagged as last");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> q_push_ready)
        else $error("push into full queue");

endmodule

`default_nettype wire

[tb/sv/tb_int_to_radix_string.sv]
`timescale 1ns / 1ps

module tb_int_to_radix_string;
    import i2rs_pkg::*;

    // pacing of both sides: every item draws its own gap
    localparam int GAP_MAX          = 13;
    localparam int RANDOM_ITEMS     = 340;
    // longest quiet stretch is a 32-digit binary item or the
    // long sink hold-off below, so this leaves a wide margin
    localparam int STALL_LIMIT      = 8000;
    localparam int SINK_HOLD_CYCLES = 1500;
    localparam int HOLD_AT_CHAR     = 120;
    localparam int DRAIN_CYCLES     = 40;

    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_TOP = 6'd63;

    typedef struct {
        logic [VAL_W-1:0]   value;
        logic [RADIX_W-1:0] radix;
        int                 gap;
    } t_num_item;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [VAL_W-1:0]   i_value = '0;
    logic [RADIX_W-1:0] i_radix = '0;
    logic               i_ready = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_char_out;
    logic               o_last;

    // numbers still to be offered, and characters still owed by the block
    t_num_item  num_q[$];
    t_text_char text_q[$];

    int items_sent    = 0;
    int chars_seen    = 0;
    int neg_items     = 0;
    int clamped_items = 0;
    int err_cnt       = 0;
    int src_wait      = 0;
    int sink_wait     = 0;
    int idle_cycles   = 0;
    int hold_cnt      = 0;
    int hold_seen     = 0;
    logic hold_done   = 1'b0;
    logic sink_hold;

    int_to_radix_string dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_radix    (i_radix),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // expected text of one number: optional minus, then digits msd first
    function automatic void predict_text(input logic [VAL_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
        logic [VAL_W-1:0]  mag;
        logic [VAL_W-1:0]  base;
        logic [VAL_W-1:0]  d;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] digits[$];
        logic              first;
        t_text_char        tc;
        // out-of-range radix is pinned to the nearest legal base
        if (radix < RADIX_MIN) begin
            base = VAL_W'(RADIX_MIN);
            clamped_items++;
        end else if (radix > RADIX_MAX) begin
            base = VAL_W'(RADIX_MAX);
            clamped_items++;
        end else begin
            base = VAL_W'(radix);
        end
        // unsigned negate: the most negative value comes out as 2^31
        mag = value[VAL_W-1] ? (~value + 1'b1) : value;
        first = 1'b1;
        while (first || mag != '0) begin
            d = mag % base;
            if (d < DIGIT_TEN) begin
                ch = CHAR_ZERO + d[CHAR_W-1:0];
            end else begin
                ch = CHAR_ALPHA_OFS + d[CHAR_W-1:0];
            end
            digits.push_front(ch);
            mag = mag / base;
            first = 1'b0;
        end
        if (value[VAL_W-1]) begin
            tc.ch = CHAR_MINUS;
            tc.last = 1'b0;
            text_q.push_back(tc);
            neg_items++;
        end
        foreach (digits[i]) begin
            tc.ch = digits[i];
            tc.last = (i == digits.size() - 1);
            text_q.push_back(tc);
        end
    endfunction

    function automatic void add_item(input logic [VAL_W-1:0] value,
                                     input logic [RADIX_W-1:0] radix, input int gap);
        t_num_item it;
        it.value = value;
        it.radix = radix;
        it.gap = gap;
        num_q.push_back(it);
    endfunction

    // mix of full-range, short, and near-limit values, either sign
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        int mode;
        mode = $urandom_range(0, 4);
        case (mode)
            0: v = $urandom();
            1: v = $urandom_range(0, 999);
            3: begin
                if ($urandom_range(0, 1) == 1) begin
                    v = 32'h8000_0000 + $urandom_range(0, 3);
                end else begin
                    v = 32'h7fff_ffff - $urandom_range(0, 3);
                end
            end
            default: v = $urandom() >> $urandom_range(0, VAL_W - 1);
        endcase
        if (mode != 0 && mode != 3 && $urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        case ($urandom_range(0, 9))
            6:       return RADIX_DEC;
            7, 8, 9: return RADIX_W'($urandom_range(0, 63));
            default: return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
        endcase
    endfunction

    // sender: holds each item until taken, then idles for the next item's gap
    always @(posedge i_clk) begin
        t_num_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_wait = (num_q.size() > 0) ? num_q[0].gap : 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_text(i_value, i_radix);
                items_sent++;
                src_wait = (num_q.size() > 0) ? num_q[0].gap : 0;
            end
            // only touch the bus when no item is left hanging
            if (!i_valid || o_ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    i_valid <= 1'b0;
                end else if (num_q.size() > 0) begin
                    nxt = num_q.pop_front();
                    i_value <= nxt.value;
                    i_radix <= nxt.radix;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // one long sink hold-off so the input queue fills and backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_seen <= 0;
            hold_done <= 1'b0;
        end else begin
            hold_seen <= hold_seen + ((o_valid && i_ready) ? 1 : 0);
            if (!hold_done && hold_seen >= HOLD_AT_CHAR) begin
                hold_cnt  <= SINK_HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    assign sink_hold = (hold_cnt != 0);

    // receiver: checks each character against the oldest owed one
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_valid && i_ready) begin
                chars_seen++;
                if (text_q.size() == 0) begin
                    err_cnt++;
                    $error("char_out: none expected, got %h", o_char_out);
                end else begin
                    want = text_q.pop_front();
                    if (o_char_out !== want.ch) begin
                        err_cnt++;
                        $error("char_out mismatch: expected %h, got %h", want.ch, o_char_out);
                    end
                    if (o_last !== want.last) begin
                        err_cnt++;
                        $error("last mismatch: expected %b, got %b", want.last, o_last);
                    end
                end
                // two windows where the sink never stalls
                if ((chars_seen >= 300 && chars_seen < 500) ||
                    (chars_seen >= 1500 && chars_seen < 1700)) begin
                    sink_wait = 0;
                end else begin
                    sink_wait = $urandom_range(0, GAP_MAX);
                end
            end
            if (sink_wait > 0) begin
                sink_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= !sink_hold;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gap;
        // directed: zero, unit values, limits, every radix edge
        add_item(32'd0,          RADIX_DEC, 0);
        add_item(32'd1,          RADIX_DEC, 0);
        add_item(32'hffff_ffff,  RADIX_DEC, 2);
        add_item(32'h7fff_ffff,  RADIX_DEC, 0);
        add_item(32'h8000_0000,  RADIX_DEC, 0);
        add_item(32'h8000_0000,  RADIX_MIN, 5);
        add_item(32'h7fff_ffff,  RADIX_MIN, 0);
        add_item(32'hffff_ffff,  RADIX_MIN, 0);
        add_item(32'h8000_0000,  RADIX_HEX, 1);
        add_item(32'h8000_0001,  RADIX_OCT, 0);
        add_item(32'd35,         RADIX_MAX, 0);
        add_item(32'd1295,       RADIX_MAX, 3);
        add_item(32'h7fff_ffff,  RADIX_MAX, 0);
        add_item(32'h8000_0000,  RADIX_MAX, 0);
        add_item(32'd255,        RADIX_HEX, 0);
        add_item(32'd10,         6'd11,     0);
        add_item(32'd0,          RADIX_MAX, 0);
        add_item(-32'sd12345,    6'd3,      4);
        // radix below and above the legal range
        add_item(32'd5,          6'd0,      0);
        add_item(-32'sd6,        6'd1,      0);
        add_item(32'd1295,       6'd37,     0);
        add_item(32'hdead_beef,  RADIX_TOP, 0);
        add_item(32'hffff_ffff,  RADIX_TOP, 0);
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // one stretch of items sent back to back
            gap = (k >= 150 && k < 190) ? 0 : $urandom_range(0, GAP_MAX);
            add_item(pick_value(), pick_radix(), gap);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (num_q.size() != 0 || i_valid) @(posedge i_clk);
        while (text_q.size() != 0) @(posedge i_clk);
        // catch any stray characters after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d numbers into %0d characters", items_sent, chars_seen);
        $display("%0d were negative, %0d used a radix outside 2..36",
                 neg_items, clamped_items);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
